// ===== hdl/scfr_pkg.sv =====
package scfr_pkg;

    // Buffer geometry
    localparam int BUF_DEPTH = 64;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int PLEN_W    = 6;

    // Frame delimiters
    localparam logic [7:0] START_BYTE = 8'hA5;
    localparam logic [7:0] END_BYTE   = 8'h5A;

    // Item operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // Receiver frame state, as reported on rx_status
    typedef enum logic [1:0] {
        RX_WAIT = 2'd0,
        RX_RECV = 2'd1,
        RX_OK   = 2'd2,
        RX_ERR  = 2'd3
    } rx_state_t;

    // Sequencer state
    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_TAKE_RD,
        CTL_TAKE_OUT
    } ctl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic step_byte;   // process a line byte, emit its status item
        logic step_fail;   // emit a failed-take item
        logic take_start;  // start walking the buffer at entry 0
        logic rd_en;       // read the buffer into the read register
        logic rd_adv;      // read the next entry and advance the index
        logic emit_byte;   // emit the byte in the read register
        logic take_done;   // walk finished: clear frame, back to wait
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic rx_ok;     // a checked frame is held
        logic out_free;  // output register can load this cycle
        logic idx_last;  // read register holds the final payload byte
    } status_t;

endpackage

// ===== hdl/scfr_ctrl.sv =====
module scfr_ctrl
    import scfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    input  logic    op,
    input  status_t sts,
    output cmd_t    cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       accept;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Input item taken only when idle and the output register can load
    assign accept = (state_reg == CTL_IDLE) && req_valid && sts.out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CTL_IDLE:
            begin
                if (accept && (op == OP_TAKE) && sts.rx_ok)
                begin
                    state_next = CTL_TAKE_RD;
                end
            end
            CTL_TAKE_RD:
            begin
                state_next = CTL_TAKE_OUT;
            end
            CTL_TAKE_OUT:
            begin
                if (sts.out_free && sts.idx_last)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            CTL_IDLE:
            begin
                req_stall = !sts.out_free;
                if (accept)
                begin
                    if (op == OP_BYTE)
                    begin
                        cmd.step_byte = 1'b1;
                    end
                    else if (sts.rx_ok)
                    begin
                        cmd.take_start = 1'b1;
                    end
                    else
                    begin
                        cmd.step_fail = 1'b1;
                    end
                end
            end
            CTL_TAKE_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            CTL_TAKE_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_byte = 1'b1;
                    if (sts.idx_last)
                    begin
                        cmd.take_done = 1'b1;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_adv = 1'b1;
                    end
                end
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/scfr_dpath.sv =====
module scfr_dpath
    import scfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           sts,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [1:0]        rx_status,
    output logic              data_valid,
    output logic [7:0]        data_byte,
    output logic [PLEN_W-1:0] payload_len,
    output logic              last,
    output logic              take_failed
);

    // Frame state
    rx_state_t        rx_state_reg, rx_state_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       running_sum_reg, running_sum_next;
    logic [7:0]       last_stored_reg, last_stored_next;

    // Buffer and readout
    logic [7:0]       mem [BUF_DEPTH];
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // Output register
    logic              out_vld_reg, out_vld_next;
    logic [1:0]        o_status_reg, o_status_next;
    logic              o_dv_reg, o_dv_next;
    logic [7:0]        o_byte_reg, o_byte_next;
    logic [PLEN_W-1:0] o_plen_reg, o_plen_next;
    logic              o_last_reg, o_last_next;
    logic              o_tf_reg, o_tf_next;

    logic              out_load;
    logic [CNT_W-1:0]  idx_plus1;

    assign idx_plus1    = CNT_W'(idx_reg) + CNT_W'(1);
    assign sts.rx_ok    = (rx_state_reg == RX_OK);
    assign sts.out_free = !out_vld_reg || !res_stall;
    assign sts.idx_last = (idx_plus1 == byte_count_reg);

    assign wr_addr = byte_count_reg[IDX_W-1:0];
    assign rd_addr = cmd.rd_adv ? IDX_W'(idx_plus1) : idx_reg;

    // Line byte handling and frame clear at the end of a take
    always_comb
    begin
        rx_state_next    = rx_state_reg;
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        last_stored_next = last_stored_reg;
        wr_en            = 1'b0;
        if (cmd.step_byte)
        begin
            case (rx_state_reg)
                RX_WAIT:
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        byte_count_next  = '0;
                        running_sum_next = '0;
                        last_stored_next = '0;
                        rx_state_next    = RX_RECV;
                    end
                end
                RX_RECV:
                begin
                    if (rx_byte != END_BYTE)
                    begin
                        wr_en            = 1'b1;
                        last_stored_next = rx_byte;
                        byte_count_next  = byte_count_reg + CNT_W'(1);
                        if (byte_count_reg != '0)
                        begin
                            running_sum_next = running_sum_reg + last_stored_reg;
                        end
                        if (byte_count_next >= CNT_W'(BUF_DEPTH))
                        begin
                            rx_state_next = RX_ERR;
                        end
                    end
                    else if (byte_count_reg < CNT_W'(2))
                    begin
                        rx_state_next = RX_ERR;
                    end
                    else if (running_sum_reg == last_stored_reg)
                    begin
                        byte_count_next = byte_count_reg - CNT_W'(1);
                        rx_state_next   = RX_OK;
                    end
                    else
                    begin
                        rx_state_next = RX_ERR;
                    end
                end
                RX_ERR:
                begin
                    byte_count_next  = '0;
                    running_sum_next = '0;
                    last_stored_next = '0;
                    rx_state_next    = RX_WAIT;
                end
                default:
                begin
                    rx_state_next = rx_state_reg;
                end
            endcase
        end
        else if (cmd.take_done)
        begin
            byte_count_next  = '0;
            running_sum_next = '0;
            last_stored_next = '0;
            rx_state_next    = RX_WAIT;
        end
    end

    // Buffer walk index
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.take_start)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_adv)
        begin
            idx_next = IDX_W'(idx_plus1);
        end
    end

    // Output register load
    assign out_load = cmd.step_byte || cmd.step_fail || cmd.emit_byte;

    always_comb
    begin
        out_vld_next  = out_vld_reg && res_stall;
        o_status_next = o_status_reg;
        o_dv_next     = o_dv_reg;
        o_byte_next   = o_byte_reg;
        o_plen_next   = o_plen_reg;
        o_last_next   = o_last_reg;
        o_tf_next     = o_tf_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
            o_dv_next    = 1'b0;
            o_byte_next  = '0;
            o_plen_next  = '0;
            o_last_next  = 1'b1;
            o_tf_next    = 1'b0;
            if (cmd.emit_byte)
            begin
                o_status_next = RX_WAIT;
                o_dv_next     = 1'b1;
                o_byte_next   = rd_data_reg;
                o_plen_next   = byte_count_reg[PLEN_W-1:0];
                o_last_next   = sts.idx_last;
            end
            else if (cmd.step_fail)
            begin
                o_status_next = rx_state_reg;
                o_tf_next     = 1'b1;
            end
            else
            begin
                o_status_next = rx_state_next;
                if (rx_state_next == RX_OK)
                begin
                    o_plen_next = byte_count_next[PLEN_W-1:0];
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_state_reg    <= RX_WAIT;
            byte_count_reg  <= '0;
            running_sum_reg <= '0;
            last_stored_reg <= '0;
            out_vld_reg     <= 1'b0;
            idx_reg         <= '0;
        end
        else
        begin
            rx_state_reg    <= rx_state_next;
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
            last_stored_reg <= last_stored_next;
            out_vld_reg     <= out_vld_next;
            idx_reg         <= idx_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        o_status_reg <= o_status_next;
        o_dv_reg     <= o_dv_next;
        o_byte_reg   <= o_byte_next;
        o_plen_reg   <= o_plen_next;
        o_last_reg   <= o_last_next;
        o_tf_reg     <= o_tf_next;
    end

    // Frame buffer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= rx_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign res_valid   = out_vld_reg;
    assign rx_status   = o_status_reg;
    assign data_valid  = o_dv_reg;
    assign data_byte   = o_byte_reg;
    assign payload_len = o_plen_reg;
    assign last        = o_last_reg;
    assign take_failed = o_tf_reg;

endmodule

// ===== hdl/sum_checked_frame_receiver_unit.sv =====
// Channel  Handshake             Payload
// request  req_valid/req_stall   op, rx_byte
// result   res_valid/res_stall   rx_status, data_valid, data_byte, payload_len,
//                                last, take_failed
//
// A line byte or a failed take gives a single item; it is loaded into the output
// register at the accepting edge and offered from the next cycle.
// A take of N payload bytes holds off requests until its last byte is loaded:
// first a buffer read, then one byte per cycle while the result side does not
// stall, each read through the single read port of the frame buffer.
// Reset (rst_n low) returns the receiver to wait; buffer contents are not cleared.
// A new request is taken while a result waits, as long as that result leaves
// the output register at the same edge.
module sum_checked_frame_receiver_unit
    import scfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              op,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [1:0]        rx_status,
    output logic              data_valid,
    output logic [7:0]        data_byte,
    output logic [PLEN_W-1:0] payload_len,
    output logic              last,
    output logic              take_failed
);

    cmd_t    cmd;
    status_t sts;

    // Sequencer
    scfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .op        (op),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Frame state, buffer and output register
    scfr_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .rx_byte     (rx_byte),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .rx_status   (rx_status),
        .data_valid  (data_valid),
        .data_byte   (data_byte),
        .payload_len (payload_len),
        .last        (last),
        .take_failed (take_failed)
    );

endmodule

// ===== verif/tb_sum_checked_frame_receiver_unit.sv =====
module tb_sum_checked_frame_receiver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import scfr_pkg::*;

    // One result item as the block should present it
    typedef struct {
        rx_state_t         status;
        logic              data_valid;
        logic [7:0]        data_byte;
        logic [PLEN_W-1:0] plen;
        logic              last;
        logic              take_failed;
    } rx_result_t;

    // One row of the directed plan; typed rows carry their own answer
    typedef struct {
        logic              op;
        logic [7:0]        b;
        bit                typed;
        rx_state_t         status;
        logic [PLEN_W-1:0] plen;
        logic              take_failed;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic              op = 1'b0;
    logic [7:0]        rx_byte = 8'h00;
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic [1:0]        rx_status;
    logic              data_valid;
    logic [7:0]        data_byte;
    logic [PLEN_W-1:0] payload_len;
    logic              last;
    logic              take_failed;

    // Receiver image kept by the testbench
    rx_state_t         m_state = RX_WAIT;
    logic [7:0]        m_buf [BUF_DEPTH];
    logic [CNT_W-1:0]  m_count = '0;
    logic [7:0]        m_sum = '0;
    logic [7:0]        m_last = '0;

    rx_result_t        due_results[$];
    plan_row_t         plan[$];
    int                items_sent = 0;
    int                mismatches = 0;
    int                stall_left = 0;
    int                quiet_left = 0;
    bit                send_quiet = 1'b0;

    sum_checked_frame_receiver_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .rx_byte     (rx_byte),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .rx_status   (rx_status),
        .data_valid  (data_valid),
        .data_byte   (data_byte),
        .payload_len (payload_len),
        .last        (last),
        .take_failed (take_failed)
    );

    always #1 clk = ~clk;

    // Idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic clear_frame_image();
        m_count = '0;
        m_sum   = '0;
        m_last  = '0;
    endtask

    // Work out the result items of one accepted item and queue them
    task automatic predict_rx_step(input logic o, input logic [7:0] b);
        rx_result_t r;
        int         n;
        r.data_valid  = 1'b0;
        r.data_byte   = '0;
        r.plen        = '0;
        r.last        = 1'b1;
        r.take_failed = 1'b0;
        if (o == OP_TAKE)
        begin
            if (m_state == RX_OK)
            begin
                n = int'(m_count);
                for (int i = 0; i < n; i++)
                begin
                    r.status     = RX_WAIT;
                    r.data_valid = 1'b1;
                    r.data_byte  = m_buf[i];
                    r.plen       = m_count[PLEN_W-1:0];
                    r.last       = (i == n - 1);
                    due_results.push_back(r);
                end
                m_state = RX_WAIT;
                clear_frame_image();
            end
            else
            begin
                r.status      = m_state;
                r.take_failed = 1'b1;
                due_results.push_back(r);
            end
        end
        else
        begin
            case (m_state)
                RX_WAIT:
                begin
                    if (b == START_BYTE)
                    begin
                        clear_frame_image();
                        m_state = RX_RECV;
                    end
                end
                RX_RECV:
                begin
                    if (b != END_BYTE)
                    begin
                        if (m_count < CNT_W'(BUF_DEPTH))
                        begin
                            if (m_count != '0)
                                m_sum = m_sum + m_last;
                            m_last = b;
                            m_buf[m_count[IDX_W-1:0]] = b;
                            m_count = m_count + CNT_W'(1);
                        end
                        // buffer full: overflow
                        if (m_count >= CNT_W'(BUF_DEPTH))
                            m_state = RX_ERR;
                    end
                    else if (m_count < CNT_W'(2))
                        m_state = RX_ERR;
                    else if (m_sum == m_last)
                    begin
                        m_count = m_count - CNT_W'(1);
                        m_state = RX_OK;
                    end
                    else
                        m_state = RX_ERR;
                end
                RX_ERR:
                begin
                    // byte after an error is dropped
                    clear_frame_image();
                    m_state = RX_WAIT;
                end
                default: ;
            endcase
            r.status = m_state;
            r.plen   = (m_state == RX_OK) ? m_count[PLEN_W-1:0] : '0;
            due_results.push_back(r);
        end
    endtask

    // Offer one item after an optional gap, wait for acceptance
    task automatic send_item(input logic o, input logic [7:0] b);
        int gap;
        gap = 0;
        if (!send_quiet && $urandom_range(0, 1) == 1)
            gap = idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            op        <= 1'($urandom_range(0, 1));
            rx_byte   <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        op        <= o;
        rx_byte   <= b;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_rx_step(o, b);
        items_sent++;
    endtask

    task automatic wait_results_drained(input int limit);
        int n;
        n = 0;
        // Idle the request side so the held item is not taken again
        req_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0 && n < limit)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    function automatic logic [7:0] any_byte_but_end();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == END_BYTE);
        return b;
    endfunction

    // Start, n payload bytes, checksum (optionally wrong), end
    task automatic send_frame(input int n, input bit corrupt);
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] b;
        do
        begin
            body.delete();
            sum = '0;
            for (int i = 0; i < n; i++)
            begin
                b = any_byte_but_end();
                body.push_back(b);
                sum = sum + b;
            end
        end
        while (sum == END_BYTE);
        if (corrupt)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == END_BYTE || b == sum);
            sum = b;
        end
        send_item(OP_BYTE, START_BYTE);
        foreach (body[i])
            send_item(OP_BYTE, body[i]);
        send_item(OP_BYTE, sum);
        send_item(OP_BYTE, END_BYTE);
    endtask

    // Fill the whole buffer with no end byte
    task automatic send_overflow_frame();
        send_item(OP_BYTE, START_BYTE);
        for (int i = 0; i < BUF_DEPTH; i++)
            send_item(OP_BYTE, any_byte_but_end());
    endtask

    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return START_BYTE;
        if (r < 40)
            return END_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic plan_row(input logic o, input logic [7:0] b, input bit typed,
                            input rx_state_t st, input logic [PLEN_W-1:0] plen,
                            input logic tf);
        plan_row_t row;
        row.op          = o;
        row.b           = b;
        row.typed       = typed;
        row.status      = st;
        row.plen        = plen;
        row.take_failed = tf;
        plan.push_back(row);
    endtask

    // Result check and result-side stall pattern
    always @(posedge clk)
    begin : result_side
        rx_result_t want;
        int         r;
        if (rst_n && res_valid && !res_stall)
        begin
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: st=%0d dv=%0b byte=%02h",
                             rx_status, data_valid, data_byte,
                             " len=%0d last=%0b fail=%0b",
                             payload_len, last, take_failed);
            end
            else
            begin
                want = due_results.pop_front();
                if (rx_status !== want.status || data_valid !== want.data_valid ||
                    data_byte !== want.data_byte || payload_len !== want.plen ||
                    last !== want.last || take_failed !== want.take_failed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp st=%0d dv=%0b byte=%02h",
                                 want.status, want.data_valid, want.data_byte,
                                 " len=%0d last=%0b fail=%0b,",
                                 want.plen, want.last, want.take_failed,
                                 " got st=%0d dv=%0b byte=%02h",
                                 rx_status, data_valid, data_byte,
                                 " len=%0d last=%0b fail=%0b",
                                 payload_len, last, take_failed);
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else if (quiet_left > 0)
        begin
            quiet_left--;
            res_stall <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                quiet_left = $urandom_range(50, 300);
                res_stall  <= 1'b0;
            end
            else if (r < 70)
                res_stall <= 1'b0;
            else
            begin
                stall_left = idle_len() - 1;
                res_stall  <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int r;
        int n;
        int scen;
        rx_result_t typed_r;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan: failed takes in each state, empty and one-byte frames,
        // byte dropped after an error, minimal frame, byte ignored while ok,
        // start byte inside the payload, extremes of the byte
        plan_row(OP_TAKE, 8'h00,      1, RX_WAIT, 6'd0, 1'b1);
        plan_row(OP_BYTE, 8'h00,      1, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, START_BYTE, 1, RX_RECV, 6'd0, 1'b0);
        plan_row(OP_TAKE, 8'hFF,      1, RX_RECV, 6'd0, 1'b1);
        plan_row(OP_BYTE, END_BYTE,   1, RX_ERR,  6'd0, 1'b0);
        plan_row(OP_TAKE, 8'h00,      1, RX_ERR,  6'd0, 1'b1);
        plan_row(OP_BYTE, 8'h33,      1, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, START_BYTE, 0, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, 8'h07,      0, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, END_BYTE,   1, RX_ERR,  6'd0, 1'b0);
        plan_row(OP_BYTE, START_BYTE, 1, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, START_BYTE, 0, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, 8'h00,      0, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, 8'h00,      0, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, END_BYTE,   1, RX_OK,   6'd1, 1'b0);
        plan_row(OP_BYTE, START_BYTE, 1, RX_OK,   6'd1, 1'b0);
        plan_row(OP_TAKE, 8'h00,      0, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, START_BYTE, 0, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, 8'hFF,      0, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, START_BYTE, 0, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, 8'h01,      0, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, 8'hA5,      0, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_BYTE, END_BYTE,   1, RX_OK,   6'd3, 1'b0);
        plan_row(OP_TAKE, 8'h00,      0, RX_WAIT, 6'd0, 1'b0);
        plan_row(OP_TAKE, 8'h00,      1, RX_WAIT, 6'd0, 1'b1);

        foreach (plan[i])
        begin
            send_item(plan[i].op, plan[i].b);
            if (plan[i].typed)
            begin
                typed_r.status      = plan[i].status;
                typed_r.data_valid  = 1'b0;
                typed_r.data_byte   = '0;
                typed_r.plen        = plan[i].plen;
                typed_r.last        = 1'b1;
                typed_r.take_failed = plan[i].take_failed;
                due_results[due_results.size() - 1] = typed_r;
            end
        end

        // Hold off until the block has drained
        wait_results_drained(50000);

        // Random frames, broken frames and noise
        scen = 0;
        while (items_sent < 410)
        begin
            send_quiet = ($urandom_range(0, 5) == 0);
            if (scen % 10 == 9)
                wait_results_drained(50000);
            if (scen == 3)
            begin
                send_frame(62, 1'b0);
                send_item(OP_TAKE, 8'($urandom_range(0, 255)));
            end
            else if (scen == 7)
                send_overflow_frame();
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 58)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        n = $urandom_range(1, 6);
                    else if (r < 95)
                        n = $urandom_range(7, 30);
                    else
                        n = $urandom_range(31, 62);
                    send_frame(n, 1'b0);
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 2))
                            send_item(OP_BYTE, noise_byte());
                    if ($urandom_range(0, 99) < 88)
                        send_item(OP_TAKE, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 9) == 0)
                        send_item(OP_TAKE, 8'($urandom_range(0, 255)));
                end
                else if (r < 68)
                begin
                    send_frame($urandom_range(1, 10), 1'b1);
                    if ($urandom_range(0, 1) == 1)
                        send_item(OP_TAKE, 8'($urandom_range(0, 255)));
                end
                else if (r < 71)
                    send_overflow_frame();
                else if (r < 83)
                begin
                    send_item(OP_BYTE, START_BYTE);
                    case ($urandom_range(0, 2))
                        0: send_item(OP_BYTE, END_BYTE);
                        1:
                        begin
                            send_item(OP_BYTE, any_byte_but_end());
                            send_item(OP_BYTE, END_BYTE);
                        end
                        default:
                        begin
                            repeat ($urandom_range(1, 5))
                                send_item(OP_BYTE, any_byte_but_end());
                            send_item(OP_TAKE, 8'($urandom_range(0, 255)));
                        end
                    endcase
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_item(1'($urandom_range(0, 1)), noise_byte());
                end
            end
            scen++;
        end

        // Drain, then let the output settle
        wait_results_drained(50000);
        repeat (80) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $display("%0d expected results never arrived", due_results.size());
            mismatches += due_results.size();
        end
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/scfr_pkg.sv
hdl/scfr_ctrl.sv
hdl/scfr_dpath.sv
hdl/sum_checked_frame_receiver_unit.sv
verif/tb_sum_checked_frame_receiver_unit.sv
